// ===== sv/rgbc_pkg.sv =====
package rgbc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int WEIGHT_BITS = 16;

    localparam int ROW_BITS  = 3 * WEIGHT_BITS;
    localparam int RING_SIZE = 2 * MAX_WIDTH + 4;
    localparam int RING_W    = $clog2(RING_SIZE);
    localparam int SIZE_W    = 11;
    localparam int PEND_W    = $clog2(MAX_WIDTH + 2);
    localparam int PIX_W     = 32;
    localparam int TAPS      = 9;
    localparam int TAP_W     = $clog2(TAPS + 1);
    localparam int PROD_W    = WEIGHT_BITS + 9;
    localparam int ACC_W     = PROD_W + 4;
    localparam int DIV_W     = 16;
    localparam int BIAS_W    = 19;
    localparam int BD_W      = BIAS_W + DIV_W;
    localparam int N_W       = ACC_W + 9 + 1;
    localparam int NUM_W     = N_W - 8;
    localparam int CNT_W     = $clog2(NUM_W + 1);

    // Register indexes
    localparam logic [2:0] REG_KTOP   = 3'd0;
    localparam logic [2:0] REG_KMID   = 3'd1;
    localparam logic [2:0] REG_KBOT   = 3'd2;
    localparam logic [2:0] REG_DIV    = 3'd3;
    localparam logic [2:0] REG_BIAS   = 3'd4;
    localparam logic [2:0] REG_MODE   = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;
    localparam logic [2:0] REG_HEIGHT = 3'd7;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic             accept;
        logic             setup;
        logic             tap_rd;
        logic [TAP_W-1:0] tap_rd_idx;
        logic             tap_mac;
        logic [TAP_W-1:0] tap_mac_idx;
        logic             fin_load;
        logic             div_step;
        logic             out_load;
    } rgbc_cmd_t;

    typedef struct packed {
        logic emit_need;
        logic out_busy;
    } rgbc_status_t;

endpackage

// ===== sv/rgbc_ctrl.sv =====
module rgbc_ctrl import rgbc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  rgbc_status_t status,
    output rgbc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_TAPS, S_FIN, S_DIV, S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign s_ready = (state_reg == S_IDLE);

    // Sequence one item: store, decide, taps, finish, divide, output
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.tap_rd_idx  = cnt_reg[TAP_W-1:0];
        cmd.tap_mac_idx = cnt_reg[TAP_W-1:0] - TAP_W'(1);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (status.emit_need) begin
                    cmd.setup  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_TAPS;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_TAPS: begin
                cmd.tap_rd  = (cnt_reg < CNT_W'(TAPS));
                cmd.tap_mac = (cnt_reg != '0);
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TAPS)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.fin_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Taps always run to completion before the divider starts
    a_taps_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TAPS && cnt_reg == CNT_W'(TAPS)) |=> (state_reg == S_FIN))
        else $error("tap sweep did not hand over to finish");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == S_DECIDE))
        else $error("accepted item not decided");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.out_busy)
        else $error("output overwritten while held");

endmodule

// ===== sv/rgbc_datapath.sv =====
module rgbc_datapath import rgbc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [ROW_BITS-1:0] cfg_wdata,
    input  logic                s_op,
    input  logic [7:0]          s_in_red,
    input  logic [7:0]          s_in_green,
    input  logic [7:0]          s_in_blue,
    input  logic [7:0]          s_in_alpha,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_red,
    output logic [7:0]          m_out_green,
    output logic [7:0]          m_out_blue,
    output logic [7:0]          m_out_alpha,
    output logic                m_frame_end,
    input  rgbc_cmd_t           cmd,
    output rgbc_status_t        status
);

    // Configuration
    logic [ROW_BITS-1:0]      ktop_reg, kmid_reg, kbot_reg;
    logic signed [DIV_W-1:0]  div_reg;
    logic signed [BIAS_W-1:0] bias_reg;
    logic [1:0]               mode_reg;
    logic [SIZE_W-1:0]        fw_reg, fh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ktop_reg <= '0;
            kmid_reg <= ROW_BITS'(256) << WEIGHT_BITS;
            kbot_reg <= '0;
            div_reg  <= DIV_W'(256);
            bias_reg <= '0;
            mode_reg <= 2'd1;
            fw_reg   <= SIZE_W'(MAX_WIDTH);
            fh_reg   <= SIZE_W'(MAX_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_KTOP:   ktop_reg <= cfg_wdata;
                REG_KMID:   kmid_reg <= cfg_wdata;
                REG_KBOT:   kbot_reg <= cfg_wdata;
                REG_DIV:    div_reg  <= cfg_wdata[DIV_W-1:0];
                REG_BIAS:   bias_reg <= cfg_wdata[BIAS_W-1:0];
                REG_MODE:   mode_reg <= cfg_wdata[1:0];
                REG_WIDTH:  fw_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_HEIGHT: fh_reg   <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size
    logic [SIZE_W-1:0] w_eff, h_eff;
    always_comb begin
        w_eff = (fw_reg == '0) ? SIZE_W'(1) :
                (fw_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : fw_reg;
        h_eff = (fh_reg == '0) ? SIZE_W'(1) :
                (fh_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : fh_reg;
    end

    // Position and ring state
    logic [RING_W-1:0] head_reg;
    logic [SIZE_W-1:0] icol_reg, irow_reg, ocol_reg, orow_reg;
    logic [PEND_W-1:0] pend_reg;
    logic              op_reg;

    logic [SIZE_W-1:0] ocol_c, orow_c;
    logic [RING_W:0]   outpos_s;
    always_comb begin
        ocol_c   = (ocol_reg > w_eff - SIZE_W'(1)) ? w_eff - SIZE_W'(1) : ocol_reg;
        orow_c   = (orow_reg > h_eff - SIZE_W'(1)) ? h_eff - SIZE_W'(1) : orow_reg;
        outpos_s = {1'b0, head_reg} - (RING_W+1)'(pend_reg);
        if (outpos_s[RING_W]) begin
            outpos_s = outpos_s + (RING_W+1)'(RING_SIZE);
        end
    end

    assign status.emit_need = (op_reg == OP_FLUSH) ? (pend_reg != '0)
                            : ((SIZE_W+1)'(pend_reg) > ((SIZE_W+1)'(w_eff) + 1'b1));

    logic [SIZE_W-1:0] ecol_reg, erow_reg;
    logic [RING_W-1:0] epos_reg;
    logic              fend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            icol_reg <= '0;
            irow_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            pend_reg <= '0;
            op_reg   <= OP_PIXEL;
        end else begin
            // Store pixel and advance input position
            if (cmd.accept) begin
                op_reg <= s_op;
                if (s_op == OP_PIXEL) begin
                    head_reg <= (head_reg == RING_W'(RING_SIZE - 1)) ? '0
                                : head_reg + RING_W'(1);
                    pend_reg <= pend_reg + PEND_W'(1);
                    if (icol_reg + SIZE_W'(1) >= w_eff) begin
                        icol_reg <= '0;
                        irow_reg <= (irow_reg + SIZE_W'(1) >= h_eff) ? '0
                                    : irow_reg + SIZE_W'(1);
                    end else begin
                        icol_reg <= icol_reg + SIZE_W'(1);
                    end
                end
            end
            // Advance output position
            if (cmd.setup) begin
                pend_reg <= pend_reg - PEND_W'(1);
                if (ocol_c + SIZE_W'(1) >= w_eff) begin
                    ocol_reg <= '0;
                    orow_reg <= (orow_c + SIZE_W'(1) >= h_eff) ? '0 : orow_c + SIZE_W'(1);
                end else begin
                    ocol_reg <= ocol_c + SIZE_W'(1);
                    orow_reg <= orow_c;
                end
            end
        end
    end

    // Latch emit geometry
    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            ecol_reg <= ocol_c;
            erow_reg <= orow_c;
            epos_reg <= outpos_s[RING_W-1:0];
            fend_reg <= (orow_c == h_eff - SIZE_W'(1)) && (ocol_c == w_eff - SIZE_W'(1));
        end
    end

    // Line memory
    logic [PIX_W-1:0]  ring_mem [RING_SIZE];
    logic [PIX_W-1:0]  rd_data_reg;
    logic [RING_W-1:0] rd_addr;

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_op == OP_PIXEL) begin
            ring_mem[head_reg] <= {s_in_alpha, s_in_blue, s_in_green, s_in_red};
        end
        if (cmd.tap_rd) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Tap address with edge replication
    logic [1:0]                ky, kx;
    logic signed [RING_W+1:0]  taddr;
    always_comb begin
        ky = (cmd.tap_rd_idx >= TAP_W'(6)) ? 2'd2 : (cmd.tap_rd_idx >= TAP_W'(3)) ? 2'd1 : 2'd0;
        kx = 2'(cmd.tap_rd_idx - TAP_W'(3) * TAP_W'(ky));
        taddr = (RING_W+2)'(epos_reg);
        if (ky == 2'd0 && erow_reg != '0) begin
            taddr = taddr - (RING_W+2)'(w_eff);
        end else if (ky == 2'd2 && erow_reg != h_eff - SIZE_W'(1)) begin
            taddr = taddr + (RING_W+2)'(w_eff);
        end
        if (kx == 2'd0 && ecol_reg != '0) begin
            taddr = taddr - (RING_W+2)'(1);
        end else if (kx == 2'd2 && ecol_reg != w_eff - SIZE_W'(1)) begin
            taddr = taddr + (RING_W+2)'(1);
        end
        if (taddr < 0) begin
            taddr = taddr + (RING_W+2)'(RING_SIZE);
        end else if (taddr >= (RING_W+2)'(RING_SIZE)) begin
            taddr = taddr - (RING_W+2)'(RING_SIZE);
        end
        rd_addr = taddr[RING_W-1:0];
    end

    // Multiply-accumulate per channel
    logic [ROW_BITS-1:0]           krow;
    logic signed [WEIGHT_BITS-1:0] wt;
    logic [1:0]                    my, mx;
    always_comb begin
        my = (cmd.tap_mac_idx >= TAP_W'(6)) ? 2'd2 : (cmd.tap_mac_idx >= TAP_W'(3)) ? 2'd1 : 2'd0;
        mx = 2'(cmd.tap_mac_idx - TAP_W'(3) * TAP_W'(my));
        unique case (my)
            2'd0:    krow = ktop_reg;
            2'd1:    krow = kmid_reg;
            default: krow = kbot_reg;
        endcase
        wt = krow[mx * WEIGHT_BITS +: WEIGHT_BITS];
    end

    logic signed [ACC_W-1:0] acc_reg [4];
    logic signed [DIV_W:0]   div_eff;
    logic signed [BD_W-1:0]  bd_reg;
    logic [7:0]              calpha_reg;

    assign div_eff = (div_reg == '0) ? (DIV_W+1)'(256) : (DIV_W+1)'(div_reg);

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            bd_reg <= BD_W'(bias_reg * div_eff);
            for (int c = 0; c < 4; c++) begin
                acc_reg[c] <= '0;
            end
        end else if (cmd.tap_mac) begin
            for (int c = 0; c < 4; c++) begin
                acc_reg[c] <= acc_reg[c]
                    + ACC_W'(wt * $signed({1'b0, rd_data_reg[8*c +: 8]}));
            end
            if (cmd.tap_mac_idx == TAP_W'(4)) begin
                calpha_reg <= rd_data_reg[31:24];
            end
        end
    end

    // Restoring dividers, one bit per step per channel
    logic [NUM_W-1:0] num_reg [4];
    logic [DIV_W-1:0] rem_reg [4];
    logic             neg_reg [4];
    logic [DIV_W-1:0] adiv;
    assign adiv = div_eff[DIV_W] ? DIV_W'(-div_eff) : div_eff[DIV_W-1:0];

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 4; c++) begin
            logic signed [N_W-1:0] n;
            logic [N_W-1:0]        mag;
            logic [DIV_W:0]        trial;
            n     = (N_W'(acc_reg[c]) <<< 8) + N_W'(bd_reg);
            mag   = n[N_W-1] ? N_W'(-n) : N_W'(n);
            mag   = mag + (N_W'(adiv) << 7);
            trial = {rem_reg[c], num_reg[c][NUM_W-1]};
            if (cmd.fin_load) begin
                num_reg[c] <= mag[N_W-1:8];
                rem_reg[c] <= '0;
                neg_reg[c] <= n[N_W-1] ^ div_eff[DIV_W];
            end else if (cmd.div_step) begin
                if (trial >= {1'b0, adiv}) begin
                    rem_reg[c] <= DIV_W'(trial - {1'b0, adiv});
                    num_reg[c] <= {num_reg[c][NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg[c] <= trial[DIV_W-1:0];
                    num_reg[c] <= {num_reg[c][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Reduce the rounded quotient to a byte: saturate when mode bit 0 is set, else wrap
    logic [7:0] res [4];
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (mode_reg[0]) begin
                if (neg_reg[c] && num_reg[c] != '0) begin
                    res[c] = 8'd0;
                end else if (num_reg[c] > NUM_W'(255)) begin
                    res[c] = 8'd255;
                end else begin
                    res[c] = num_reg[c][7:0];
                end
            end else begin
                res[c] = neg_reg[c] ? 8'(-num_reg[c][7:0]) : num_reg[c][7:0];
            end
        end
    end

    // Output register
    logic m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_out_red   <= res[0];
            m_out_green <= res[1];
            m_out_blue  <= res[2];
            m_out_alpha <= mode_reg[1] ? calpha_reg : res[3];
            m_frame_end <= fend_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.out_busy = m_valid_reg && !m_ready;

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < RING_W'(RING_SIZE))
        else $error("ring head out of range");
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= PEND_W'(MAX_WIDTH + 2))
        else $error("pending count overflow");
    a_setup_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.setup |-> (pend_reg != '0))
        else $error("emit with nothing pending");

endmodule

// ===== sv/rgba_conv3x3_filter.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_op, s_in_red/green/blue/alpha
// m_        out  m_valid/m_ready    m_out_red/green/blue/alpha, m_frame_end
// cfg_      in   cfg_wr_en          cfg_addr, cfg_wdata
//
// An item that makes no output is only accepted and decided; one that emits also
// passes through 9 single-port line memory reads, each read registered before its
// multiply-accumulate, one finish step, a 31-step restoring divider and the output
// load, plus any wait for the output register.
// Reset is synchronous, active low; the line memory is not cleared.
// A stalled output register holds the next result back in its last step only.
module rgba_conv3x3_filter import rgbc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [ROW_BITS-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [7:0]          s_in_red,
    input  logic [7:0]          s_in_green,
    input  logic [7:0]          s_in_blue,
    input  logic [7:0]          s_in_alpha,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_red,
    output logic [7:0]          m_out_green,
    output logic [7:0]          m_out_blue,
    output logic [7:0]          m_out_alpha,
    output logic                m_frame_end
);

    rgbc_cmd_t    cmd;
    rgbc_status_t status;

    rgbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rgbc_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_op        (s_op),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .s_in_alpha  (s_in_alpha),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_alpha (m_out_alpha),
        .m_frame_end (m_frame_end),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
